>>> hw/rtl/pme_pkg.sv
// Shared types, register codes and the entropy table builder for the pairwise match entropy block.
package pme_pkg;

    // Configuration register indexes.
    localparam logic CFG_RECORD_COUNT = 1'b0;
    localparam logic CFG_NORM_LENGTH  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [4:0] RECORD_COUNT_RESET = 5'd10;
    localparam logic [7:0] NORM_LENGTH_RESET  = 8'd70;

    // Symbols that never count as a match.
    localparam logic [7:0] SYM_COMMA   = 8'h2C;
    localparam logic [7:0] SYM_NEWLINE = 8'h0A;

    // Entropy table geometry and arithmetic widths.
    localparam int ENT_ENTRIES = 1024;
    localparam int ENT_AW      = 10;
    localparam int ENT_DW      = 16;
    localparam int QUOT_W      = 16;
    localparam int FRAC_W      = 6;
    localparam int ACC_W       = 32;
    localparam int OUT_W       = 24;
    localparam logic [63:0] LN2_Q24 = 64'd11629080;

    typedef logic [ENT_DW-1:0] ent_tab_t [ENT_ENTRIES];

    // Status of the serial divider.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

    // log2(k) in Q.30 for k in 1..1024, by repeated squaring.
    function automatic logic [63:0] log2_q30(input logic [63:0] k);
        logic [63:0] n;
        logic [63:0] y;
        logic [63:0] r;
        n = 64'd0;
        for (int b = 0; b < 10; b++) begin
            if (n == 64'(b) && (k >> (b + 1)) != 64'd0) begin
                n = n + 64'd1;
            end
        end
        y = k << (64'd30 - n);
        r = n << 30;
        for (int i = 29; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    // -x ln x for x = k/1024, in Q0.16.
    function automatic logic [63:0] xlogx_term(input logic [63:0] k);
        logic [63:0] a;
        if (k == 64'd0 || k > 64'd1024) begin
            return 64'd0;
        end
        a = ((64'd10 << 30) - log2_q30(k)) >> 10;
        return (a * k * LN2_Q24 + (64'd1 << 37)) >> 38;
    endfunction

    // Binary entropy H(m/1024) for every table entry.
    function automatic ent_tab_t build_ent_table();
        ent_tab_t    t;
        logic [63:0] v;
        for (int m = 0; m < ENT_ENTRIES; m++) begin
            v = xlogx_term(64'(m)) + xlogx_term(64'(ENT_ENTRIES - m));
            t[m] = v[ENT_DW-1:0];
        end
        return t;
    endfunction

endpackage

>>> hw/rtl/pme_store.sv
// Record byte store and record length store, one write port and two registered read ports.
module pme_store #(
    parameter int REC_W = 4,
    parameter int SYM_W = 7,
    parameter int LEN_W = 8,
    parameter int DEPTH_R = 16,
    parameter int DEPTH_S = 128
) (
    input  logic             aclk,
    input  logic             sym_we,
    input  logic [REC_W-1:0] sym_wr_rec,
    input  logic [SYM_W-1:0] sym_wr_pos,
    input  logic [7:0]       sym_wr_data,
    input  logic             len_we,
    input  logic [LEN_W-1:0] len_wr_data,
    input  logic [REC_W-1:0] rd_rec_a,
    input  logic [REC_W-1:0] rd_rec_b,
    input  logic [SYM_W-1:0] rd_pos,
    output logic [7:0]       sym_a,
    output logic [7:0]       sym_b,
    output logic [LEN_W-1:0] len_a,
    output logic [LEN_W-1:0] len_b
);

    logic [7:0]       sym_mem [DEPTH_R][DEPTH_S];
    logic [LEN_W-1:0] len_mem [DEPTH_R];

    // Writes come from the loader, the length at the close of each record.
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[sym_wr_rec][sym_wr_pos] <= sym_wr_data;
        end
        if (len_we) begin
            len_mem[sym_wr_rec] <= len_wr_data;
        end
    end

    // Registered reads for the pair under comparison.
    always_ff @(posedge aclk) begin
        sym_a <= sym_mem[rd_rec_a][rd_pos];
        sym_b <= sym_mem[rd_rec_b][rd_pos];
        len_a <= len_mem[rd_rec_a];
        len_b <= len_mem[rd_rec_b];
    end

endmodule

>>> hw/rtl/pme_div.sv
// Restoring divider producing a 16-bit fraction, one quotient bit per cycle.
module pme_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [7:0]          dividend,
    input  logic [7:0]          divisor,
    output pme_pkg::div_stat_t  stat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  step_reg, step_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [pme_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [8:0]  rem_sh;

    // One shift-and-subtract step per cycle; the dividend is below the divisor.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        rem_sh    = {rem_reg, 1'b0};
        if (start) begin
            busy_next = 1'b1;
            step_next = 5'd0;
            rem_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next  = 8'(rem_sh - {1'b0, dvs_reg});
                quot_next = {quot_reg[pme_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[7:0];
                quot_next = {quot_reg[pme_pkg::QUOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(pme_pkg::QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

>>> hw/rtl/pme_ent_rom.sv
// Binary entropy lookup table with a registered read port.
module pme_ent_rom (
    input  logic                        aclk,
    input  logic [pme_pkg::ENT_AW-1:0]  addr,
    output logic [pme_pkg::ENT_DW-1:0]  data
);

    localparam pme_pkg::ent_tab_t ENT_TABLE = pme_pkg::build_ent_table();

    always_ff @(posedge aclk) begin
        data <= ENT_TABLE[addr];
    end

endmodule

>>> hw/rtl/pairwise_match_entropy_core.sv
// Top level of the pairwise match entropy block: loader, pair sequencer and accumulator.
//
// Usage: records arrive on the s_ channel one byte per transaction; s_tlast closes a
// record and s_tuser closes the set (and its record). Bytes load at one per cycle while
// s_tready is high. On the set-closing byte the block drops s_tready and walks every
// pair of the first min(record_count, loaded) records. For each pair it compares the
// bytes of both records up to the shorter record length, one memory read pair per byte,
// and when the pair contributes it runs the serial divider, then two table reads, two
// interpolation multiplies and one accumulate. One result then goes out on the m_
// channel: the summed entropy in Q8.16 and a flag set when it was clamped.
// The result sits in an output register; loading of the next set may start while the
// receiver stalls it, and a new result waits until the previous one is taken.
// The cfg_ channel writes record_count (index 0) and norm_length (index 1), always ready.
// Reset (aresetn low, synchronous) empties the loader, clears the output and restores
// record_count to 10 and norm_length to 70; the record memories need no clearing.
module pairwise_match_entropy_core #(
    parameter int MAX_RECORDS = 16,
    parameter int MAX_SYMBOLS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // end_of_record
    input  logic        s_tuser,   // end_of_set
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] entropy_value
    output logic        m_tuser,   // saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int REC_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int SYM_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int RCNT_W = $clog2(MAX_RECORDS + 1);
    localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int N_W    = (RCNT_W > 5) ? RCNT_W : 5;
    localparam int CMP_W  = (LEN_W > 8) ? LEN_W : 8;
    localparam int P_W    = 23;
    localparam int V_W    = 17;

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_LEN   = 4'd1;
    localparam logic [3:0] ST_LENW  = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_CMP   = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_DIVW  = 4'd6;
    localparam logic [3:0] ST_ROMA  = 4'd7;
    localparam logic [3:0] ST_ROMB  = 4'd8;
    localparam logic [3:0] ST_MUL0  = 4'd9;
    localparam logic [3:0] ST_MUL1  = 4'd10;
    localparam logic [3:0] ST_ACC   = 4'd11;
    localparam logic [3:0] ST_NEXT  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [RCNT_W-1:0] rec_idx_reg, rec_idx_next;
    logic [LEN_W-1:0]  sym_idx_reg, sym_idx_next;
    logic [4:0]        rc_reg, rc_next;
    logic [7:0]        norm_reg, norm_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [REC_W-1:0]  i_reg, i_next;
    logic [REC_W-1:0]  j_reg, j_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]  lim_reg, lim_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [pme_pkg::QUOT_W-1:0] s_reg, s_next;
    logic [pme_pkg::ENT_DW-1:0] lo_reg, lo_next;
    logic [pme_pkg::ENT_DW-1:0] hi_reg, hi_next;
    logic [P_W-1:0]    p_reg, p_next;
    logic [pme_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    logic [pme_pkg::OUT_W-1:0] out_data_reg, out_data_next;
    logic              out_sat_reg, out_sat_next;

    logic              in_acc;
    logic              rec_room;
    logic              sym_room;
    logic [RCNT_W-1:0] rec_idx_inc;
    logic [LEN_W-1:0]  sym_idx_inc;
    logic [N_W-1:0]    n_new;
    logic              sym_we;
    logic              len_we;
    logic [7:0]        sym_a, sym_b;
    logic [LEN_W-1:0]  len_a, len_b;
    logic              div_start;
    pme_pkg::div_stat_t div_stat;
    logic [pme_pkg::ENT_AW-1:0] ent_idx;
    logic [pme_pkg::ENT_AW-1:0] rom_addr;
    logic [pme_pkg::ENT_DW-1:0] rom_data;
    logic [pme_pkg::FRAC_W-1:0] frac;
    logic [pme_pkg::FRAC_W:0]   frac_inv;
    logic [V_W-1:0]    ent_v;
    logic [pme_pkg::ACC_W:0] acc_sum;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_sat_reg;

    // Loader bookkeeping.
    assign rec_room    = (rec_idx_reg < RCNT_W'(MAX_RECORDS));
    assign sym_room    = (sym_idx_reg < LEN_W'(MAX_SYMBOLS));
    assign sym_we      = in_acc && rec_room && sym_room;
    assign sym_idx_inc = sym_room ? sym_idx_reg + LEN_W'(1) : sym_idx_reg;
    assign len_we      = in_acc && (s_tlast || s_tuser) && rec_room;
    assign rec_idx_inc = rec_room ? rec_idx_reg + RCNT_W'(1) : rec_idx_reg;
    assign n_new       = (N_W'(rc_reg) < N_W'(rec_idx_inc)) ? N_W'(rc_reg) : N_W'(rec_idx_inc);

    pme_store #(
        .REC_W   (REC_W),
        .SYM_W   (SYM_W),
        .LEN_W   (LEN_W),
        .DEPTH_R (MAX_RECORDS),
        .DEPTH_S (MAX_SYMBOLS)
    ) u_store (
        .aclk        (aclk),
        .sym_we      (sym_we),
        .sym_wr_rec  (rec_idx_reg[REC_W-1:0]),
        .sym_wr_pos  (sym_idx_reg[SYM_W-1:0]),
        .sym_wr_data (s_tdata),
        .len_we      (len_we),
        .len_wr_data (sym_idx_inc),
        .rd_rec_a    (i_reg),
        .rd_rec_b    (j_reg),
        .rd_pos      (k_reg[SYM_W-1:0]),
        .sym_a       (sym_a),
        .sym_b       (sym_b),
        .len_a       (len_a),
        .len_b       (len_b)
    );

    assign div_start = (state_reg == ST_CHK) && (cnt_reg != '0) &&
                       (CMP_W'(cnt_reg) < CMP_W'(norm_reg));

    pme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cnt_reg[7:0]),
        .divisor  (norm_reg),
        .stat     (div_stat)
    );

    // Table index and interpolation weight come from S in Q0.16.
    assign ent_idx  = s_reg[pme_pkg::QUOT_W-1:pme_pkg::FRAC_W];
    assign frac     = s_reg[pme_pkg::FRAC_W-1:0];
    assign frac_inv = 7'd64 - {1'b0, frac};
    assign rom_addr = (state_reg == ST_ROMB) ? ent_idx + 10'd1 : ent_idx;

    pme_ent_rom u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign ent_v   = V_W'(p_reg >> pme_pkg::FRAC_W);
    assign acc_sum = {1'b0, acc_reg} + (pme_pkg::ACC_W + 1)'(ent_v);

    // Sequencer: loading, pair walk, compare, divide, interpolate, accumulate.
    always_comb begin
        state_next     = state_reg;
        rec_idx_next   = rec_idx_reg;
        sym_idx_next   = sym_idx_reg;
        rc_next        = rc_reg;
        norm_next      = norm_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        lim_next       = lim_reg;
        cnt_next       = cnt_reg;
        s_next         = s_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pme_pkg::CFG_RECORD_COUNT: rc_next   = cfg_data[4:0];
                pme_pkg::CFG_NORM_LENGTH:  norm_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    sym_idx_next = sym_idx_inc;
                    if (s_tlast || s_tuser) begin
                        rec_idx_next = rec_idx_inc;
                        sym_idx_next = '0;
                    end
                    if (s_tuser) begin
                        rec_idx_next = '0;
                        n_next       = n_new;
                        acc_next     = '0;
                        i_next       = REC_W'(0);
                        j_next       = REC_W'(1);
                        if (norm_reg == 8'd0 || n_new < N_W'(2)) begin
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_LEN;
                        end
                    end
                end
            end
            ST_LEN: state_next = ST_LENW;
            ST_LENW: begin
                lim_next = (len_a < len_b) ? len_a : len_b;
                k_next   = '0;
                cnt_next = '0;
                if (len_a == '0 || len_b == '0) begin
                    state_next = ST_CHK;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: state_next = ST_CMP;
            ST_CMP: begin
                if (sym_a == sym_b && sym_a != pme_pkg::SYM_COMMA &&
                    sym_a != pme_pkg::SYM_NEWLINE) begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
                k_next = k_reg + LEN_W'(1);
                if (k_reg + LEN_W'(1) == lim_reg) begin
                    state_next = ST_CHK;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_CHK: begin
                if (div_start) begin
                    state_next = ST_DIVW;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    s_next     = div_stat.quot;
                    state_next = ST_ROMA;
                end
            end
            ST_ROMA: state_next = ST_ROMB;
            ST_ROMB: begin
                lo_next    = rom_data;
                state_next = ST_MUL0;
            end
            ST_MUL0: begin
                hi_next    = (ent_idx == '1) ? '0 : rom_data;
                p_next     = P_W'(lo_reg * frac_inv);
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                p_next     = p_reg + P_W'(hi_reg * frac) + P_W'(32);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_sum[pme_pkg::ACC_W] ? '1 : acc_sum[pme_pkg::ACC_W-1:0];
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if ((N_W + 1)'(j_reg) + (N_W + 1)'(1) < (N_W + 1)'(n_reg)) begin
                    j_next     = j_reg + REC_W'(1);
                    state_next = ST_LEN;
                end else if ((N_W + 1)'(i_reg) + (N_W + 1)'(2) < (N_W + 1)'(n_reg)) begin
                    i_next     = i_reg + REC_W'(1);
                    j_next     = i_reg + REC_W'(2);
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    if (acc_reg > pme_pkg::ACC_W'(24'hFFFFFF)) begin
                        out_data_next = '1;
                        out_sat_next  = 1'b1;
                    end else begin
                        out_data_next = acc_reg[pme_pkg::OUT_W-1:0];
                        out_sat_next  = 1'b0;
                    end
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            rec_idx_reg   <= '0;
            sym_idx_reg   <= '0;
            rc_reg        <= pme_pkg::RECORD_COUNT_RESET;
            norm_reg      <= pme_pkg::NORM_LENGTH_RESET;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rec_idx_reg   <= rec_idx_next;
            sym_idx_reg   <= sym_idx_next;
            rc_reg        <= rc_next;
            norm_reg      <= norm_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        lim_reg      <= lim_next;
        cnt_reg      <= cnt_next;
        s_reg        <= s_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        p_reg        <= p_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    // A reset leaves no result pending.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A clamped result always carries the full-scale value.
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'hFFFFFF)
        else $error("saturated result is not full scale");

    // The second record of a pair always follows the first.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD || state_reg == ST_CMP |-> j_reg > i_reg)
        else $error("pair indexes out of order");

    // Compare reads stay below the shorter record length.
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> k_reg < lim_reg)
        else $error("compare position past record end");

    // The divider only starts on a nonzero count and a nonzero norm length.
    a_div_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> cnt_reg != '0 && norm_reg != 8'd0)
        else $error("divider started with bad operands");

endmodule
